>>> sv/zst_pkg.sv
// ----------------------------------------------------------------------------
// zst_pkg
// Shared types, codes and the pixel deletion test of the thinning core.
// ----------------------------------------------------------------------------
package zst_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  localparam int CfgWidth = 9;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [7:0] iterations_done;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     in_image;
  } cmd_t;

  // p[0]..p[7] hold the ring N, NE, E, SE, S, SW, W, NW
  function automatic logic zst_delete(input logic [7:0] p, input logic second);
    logic [3:0] cnt;
    logic [3:0] trans;
    logic       prod;
    cnt   = 4'd0;
    trans = 4'd0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + {3'd0, p[k]};
      if (!p[k] && p[(k + 1) & 7]) begin
        trans = trans + 4'd1;
      end
    end
    if (!second) begin
      prod = (p[0] & p[2] & p[4]) | (p[2] & p[4] & p[6]);
    end else begin
      prod = (p[0] & p[2] & p[6]) | (p[0] & p[4] & p[6]);
    end
    return (cnt >= 4'd2) && (cnt <= 4'd6) && (trans == 4'd1) && !prod;
  endfunction

endpackage

>>> sv/zhang_suen_thinning_core.sv
// ----------------------------------------------------------------------------
// zhang_suen_thinning_core
// Frame store with in-place Zhang-Suen thinning and pixel access.
// ----------------------------------------------------------------------------
// A pixel read holds the back end longer than a pixel write or an unused code,
// because the frame store read port is registered; with results taken at once,
// writes stream at one item per cycle. A run walks the saturated image size
// once per subiteration at one pixel per cycle, then drains the window
// pipeline; it holds the back end until it ends, as it takes the single frame
// store read port, and items queue in a two-entry buffer meanwhile.
module zhang_suen_thinning_core import zst_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CfgWidth-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int DW = (MW + 1 > CfgWidth) ? MW + 1 : CfgWidth;

  logic [CfgWidth-1:0] cols_r, rows_r;
  logic [7:0]          limit_r;
  logic [DW-1:0]       width, height;
  logic                q_full, q_push, q_valid, q_pop;
  cmd_t                push_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= CfgWidth'(256);
      rows_r  <= CfgWidth'(256);
      limit_r <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_r  <= cfg_wdata;
        CFG_ROWS:    rows_r  <= cfg_wdata;
        CFG_LIMIT:   limit_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // clamp the dimensions between 3 and the frame size
  always_comb begin
    width = DW'(cols_r);
    if (width < DW'(3)) begin
      width = DW'(3);
    end else if (width > DW'(MAX_COLUMNS)) begin
      width = DW'(MAX_COLUMNS);
    end
    height = DW'(rows_r);
    if (height < DW'(3)) begin
      height = DW'(3);
    end else if (height > DW'(MAX_ROWS)) begin
      height = DW'(MAX_ROWS);
    end
  end

  zst_front #(.DW(DW)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .width    (width),
    .height   (height),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  zst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  zst_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .DW          (DW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .width     (width),
    .height    (height),
    .limit     (limit_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> sv/zst_front.sv
// ----------------------------------------------------------------------------
// zst_front
// Accepts items, checks the address against the image size, pushes commands.
// ----------------------------------------------------------------------------
module zst_front import zst_pkg::*; #(
  parameter int DW = 9
) (
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_item,
  input  logic [DW-1:0] width,
  input  logic [DW-1:0] height,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic in_image;

  assign in_image = (DW'(in_item.row) < height) && (DW'(in_item.column) < width);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.item     = in_item;
    q_cmd.in_image = in_image;
  end

endmodule

>>> sv/zst_queue.sv
// ----------------------------------------------------------------------------
// zst_queue
// Two-entry command queue between the front and the execution back end.
// ----------------------------------------------------------------------------
module zst_queue import zst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> sv/zst_back.sv
// ----------------------------------------------------------------------------
// zst_back
// Frame store, raster scan thinning engine and result register.
// ----------------------------------------------------------------------------
module zst_back import zst_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int DW          = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  input  logic [DW-1:0] width,
  input  logic [DW-1:0] height,
  input  logic [7:0]    limit,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_item
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    frame_mem [2**AW];
  logic [1:0]    lb_mem [MAX_COLUMNS];

  logic [RW-1:0] sr_r, sr_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic          s1_valid_r, s2_valid_r;
  logic [RW-1:0] s1_r_r, s2_r_r;
  logic [CW-1:0] s1_c_r, s2_c_r;
  logic [7:0]    fr_rd_r;
  logic [1:0]    lb_rd_r;
  logic [2:0]    top_r, mid_r, bot_r;
  logic          pix_nz;

  logic [7:0]    iter_r, iter_nxt, iter_inc;
  logic          sub_r, sub_nxt;
  logic          del_flag_r, del_flag_nxt;
  logic [1:0]    drain_r, drain_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_inside_r, rd_inside_nxt;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r;
  logic          out_load;
  out_item_t     out_data;
  logic          out_free;

  logic [7:0]    ring;
  logic          del_we;
  logic [AW-1:0] del_addr, cmd_addr, fr_raddr, fr_waddr;
  logic          fr_we;
  logic [7:0]    fr_wdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (state_r == ST_IDLE) && !rd_pend_r && out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign iter_inc  = iter_r + 8'd1;

  assign cmd_addr = {RW'(q_cmd.item.row), CW'(q_cmd.item.column)};
  assign fr_raddr = (state_r == ST_SCAN) ? {sr_r, sc_r} : cmd_addr;
  assign pix_nz   = (fr_rd_r != 8'd0);

  // window centre sits at (s2 row - 1, s2 column - 1)
  assign ring = {top_r[0], mid_r[0], bot_r[0], bot_r[1],
                 bot_r[2], mid_r[2], top_r[2], top_r[1]};
  assign del_we   = s2_valid_r && (s2_r_r > RW'(1)) && (s2_c_r > CW'(1)) &&
                    mid_r[1] && zst_delete(ring, sub_r);
  assign del_addr = {s2_r_r - RW'(1), s2_c_r - CW'(1)};

  always_comb begin
    fr_we    = del_we;
    fr_waddr = del_addr;
    fr_wdata = 8'd0;
    if (q_pop && q_cmd.item.operation == OP_WRITE && q_cmd.in_image) begin
      fr_we    = 1'b1;
      fr_waddr = cmd_addr;
      fr_wdata = q_cmd.item.pixel_in;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    iter_nxt      = iter_r;
    sub_nxt       = sub_r;
    del_flag_nxt  = del_flag_r | del_we;
    drain_nxt     = drain_r;
    rd_pend_nxt   = 1'b0;
    rd_inside_nxt = rd_inside_r;
    out_load      = 1'b0;
    out_data      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (rd_pend_r) begin
          out_load           = 1'b1;
          out_data.pixel_out = rd_inside_r ? fr_rd_r : 8'd0;
        end else if (q_pop) begin
          unique case (q_cmd.item.operation)
            OP_READ: begin
              rd_pend_nxt   = 1'b1;
              rd_inside_nxt = q_cmd.in_image;
            end
            OP_RUN: begin
              if (limit == 8'd0) begin
                out_load = 1'b1;
              end else begin
                state_nxt    = ST_SCAN;
                sr_nxt       = '0;
                sc_nxt       = '0;
                iter_nxt     = 8'd0;
                sub_nxt      = 1'b0;
                del_flag_nxt = 1'b0;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (DW'(sc_r) == width - DW'(1)) begin
          sc_nxt = '0;
          if (DW'(sr_r) == height - DW'(1)) begin
            state_nxt = ST_DRAIN;
            drain_nxt = 2'd3;
          end else begin
            sr_nxt = sr_r + RW'(1);
          end
        end else begin
          sc_nxt = sc_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r - 2'd1;
        if (drain_r == 2'd0) begin
          sr_nxt = '0;
          sc_nxt = '0;
          if (!sub_r) begin
            sub_nxt   = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            iter_nxt = iter_inc;
            if (!del_flag_r || iter_inc == limit) begin
              state_nxt = ST_DONE;
            end else begin
              sub_nxt      = 1'b0;
              del_flag_nxt = 1'b0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_data.iterations_done = iter_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      del_flag_r  <= 1'b0;
      sub_r       <= 1'b0;
      iter_r      <= 8'd0;
      drain_r     <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= (state_r == ST_SCAN);
      s2_valid_r  <= s1_valid_r;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      del_flag_r  <= del_flag_nxt;
      sub_r       <= sub_nxt;
      iter_r      <= iter_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r        <= sr_nxt;
    sc_r        <= sc_nxt;
    rd_inside_r <= rd_inside_nxt;
    s1_r_r      <= sr_r;
    s1_c_r      <= sc_r;
    s2_r_r      <= s1_r_r;
    s2_c_r      <= s1_c_r;
    if (out_load) begin
      out_item_r <= out_data;
    end
    // shift the 3x3 window; bit 2 is the newest column
    if (s1_valid_r) begin
      top_r <= {lb_rd_r[1], top_r[2:1]};
      mid_r <= {lb_rd_r[0], mid_r[2:1]};
      bot_r <= {pix_nz, bot_r[2:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= fr_wdata;
    end
    fr_rd_r <= frame_mem[fr_raddr];
  end

  // line buffer: bit 1 two rows up, bit 0 one row up
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      lb_mem[s1_c_r] <= {lb_rd_r[0], pix_nz};
    end
    lb_rd_r <= lb_mem[sc_r];
  end

  a_del_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    del_we |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("deletion outside a run");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_valid_r && !s2_valid_r))
    else $error("scan pipeline busy while idle");

  a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("read data returned with result slot full");

endmodule
